>>> design/swthr_pkg.sv
package swthr_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int FRAME_BITS     = 40;
    localparam int LONG_W         = 20;
    localparam int SHORT_W        = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = LONG_W;
    localparam int READING_W      = 16;
    localparam int BYTE_W         = 8;
    localparam int BIT_CNT_W      = $clog2(FRAME_BITS + 1);

    localparam logic [READING_W-1:0] INVALID_READING = 16'h955C;
    localparam logic [READING_W-1:0] SCALE_X100      = 16'd100;

    localparam logic [LONG_W-1:0]  PRE_HIGH_RST   = 20'd200000;
    localparam logic [LONG_W-1:0]  START_LOW_RST  = 20'd18000;
    localparam logic [SHORT_W-1:0] RELEASE_RST    = 10'd40;
    localparam logic [SHORT_W-1:0] TIMEOUT_RST    = 10'd100;
    localparam logic [SHORT_W-1:0] ONE_THRESH_RST = 10'd40;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_HIGH   = 3'd0,
        CFG_START_LOW  = 3'd1,
        CFG_RELEASE    = 3'd2,
        CFG_TIMEOUT    = 3'd3,
        CFG_ONE_THRESH = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_PRE_HIGH  = 4'd1,
        PH_START_LOW = 4'd2,
        PH_RELEASE   = 4'd3,
        PH_WAIT_HIGH = 4'd4,
        PH_WAIT_LOW  = 4'd5,
        PH_BIT_LOW   = 4'd6,
        PH_BIT_HIGH  = 4'd7
    } t_phase;

    typedef struct packed {
        logic [LONG_W-1:0]  pre_high_us;
        logic [LONG_W-1:0]  start_low_us;
        logic [SHORT_W-1:0] release_us;
        logic [SHORT_W-1:0] timeout_us;
        logic [SHORT_W-1:0] one_threshold_us;
    } t_cfg;

    typedef struct packed {
        logic func;
        logic line_level;
    } t_item;

    typedef struct packed {
        logic                        drive_line;
        logic                        drive_high;
        logic                        busy_res;
        logic                        done_res;
        logic                        success;
        logic signed [READING_W-1:0] temperature_x100;
        logic signed [READING_W-1:0] humidity_x100;
    } t_result;

endpackage

>>> design/swthr_in_stage.sv
module swthr_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  swthr_pkg::t_item   i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output swthr_pkg::t_item   o_item
);

    logic             r_valid;
    logic             n_valid;
    swthr_pkg::t_item r_item;
    logic             accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> design/swthr_seq.sv
module swthr_seq #(
    parameter int TIMER_BITS = swthr_pkg::TIMER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  swthr_pkg::t_item   i_item,
    input  swthr_pkg::t_cfg    i_cfg,
    output swthr_pkg::t_result o_result
);

    localparam int CMP_W = (TIMER_BITS > swthr_pkg::LONG_W) ? TIMER_BITS : swthr_pkg::LONG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    swthr_pkg::t_phase                     r_phase, n_phase;
    logic [TIMER_BITS-1:0]                 r_timer, n_timer;
    logic [swthr_pkg::SHORT_W-1:0]         r_high_width, n_high_width;
    logic [swthr_pkg::BIT_CNT_W-1:0]       r_bit_count, n_bit_count;
    logic [swthr_pkg::FRAME_BITS-1:0]      r_frame, n_frame;
    logic [swthr_pkg::READING_W-1:0]       r_temp, n_temp;
    logic [swthr_pkg::READING_W-1:0]       r_hum, n_hum;
    logic                                  r_success, n_success;

    logic                                  lvl;
    logic                                  restart;
    logic [TIMER_BITS-1:0]                 timer_base;
    logic [TIMER_BITS-1:0]                 timer_inc;
    logic                                  timed_out;
    logic [swthr_pkg::LONG_W-1:0]          dur_sel;
    logic                                  drive_hit;
    swthr_pkg::t_phase                     drive_next;
    logic [swthr_pkg::FRAME_BITS-1:0]      frame_new;
    logic [swthr_pkg::BIT_CNT_W-1:0]       bits_new;
    logic [swthr_pkg::BYTE_W-1:0]          hum_int, hum_dec, temp_int, temp_dec, csum;
    logic [swthr_pkg::BYTE_W-1:0]          byte_sum;
    logic                                  frame_ok;
    logic [swthr_pkg::READING_W-1:0]       temp_calc, hum_calc;
    logic                                  done;

    assign lvl = i_item.line_level;

    always_comb begin
        case (r_phase)
            swthr_pkg::PH_WAIT_HIGH: restart = lvl;
            swthr_pkg::PH_WAIT_LOW:  restart = !lvl;
            swthr_pkg::PH_BIT_HIGH:  restart = !lvl;
            default:                 restart = 1'b0;
        endcase
    end

    assign timer_base = restart ? '0 : r_timer;
    assign timer_inc  = (timer_base == TIMER_MAX) ? timer_base : timer_base + 1'b1;
    assign timed_out  = timer_inc >=
        {{(TIMER_BITS - swthr_pkg::SHORT_W){1'b0}}, i_cfg.timeout_us};

    always_comb begin
        case (r_phase)
            swthr_pkg::PH_PRE_HIGH: begin
                dur_sel    = i_cfg.pre_high_us;
                drive_next = swthr_pkg::PH_START_LOW;
            end
            swthr_pkg::PH_START_LOW: begin
                dur_sel    = i_cfg.start_low_us;
                drive_next = swthr_pkg::PH_RELEASE;
            end
            default: begin
                dur_sel    = {{(swthr_pkg::LONG_W - swthr_pkg::SHORT_W){1'b0}},
                              i_cfg.release_us};
                drive_next = swthr_pkg::PH_WAIT_HIGH;
            end
        endcase
    end

    assign drive_hit = (CMP_W'(timer_inc) >= CMP_W'(dur_sel)) || (timer_inc == TIMER_MAX);

    assign frame_new = {r_frame[swthr_pkg::FRAME_BITS-2:0],
                        (r_high_width > i_cfg.one_threshold_us)};
    assign bits_new  = r_bit_count + 1'b1;
    assign hum_int   = frame_new[39:32];
    assign hum_dec   = frame_new[31:24];
    assign temp_int  = frame_new[23:16];
    assign temp_dec  = frame_new[15:8];
    assign csum      = frame_new[7:0];
    assign byte_sum  = hum_int + hum_dec + temp_int + temp_dec;
    assign frame_ok  = (byte_sum == csum);
    assign temp_calc = swthr_pkg::READING_W'(temp_int) * swthr_pkg::SCALE_X100
                       + swthr_pkg::READING_W'(temp_dec);
    assign hum_calc  = swthr_pkg::READING_W'(hum_int) * swthr_pkg::SCALE_X100
                       + swthr_pkg::READING_W'(hum_dec);

    always_comb begin
        n_phase      = r_phase;
        n_timer      = r_timer;
        n_high_width = r_high_width;
        n_bit_count  = r_bit_count;
        n_frame      = r_frame;
        n_temp       = r_temp;
        n_hum        = r_hum;
        n_success    = r_success;
        done         = 1'b0;
        if (i_item.func == swthr_pkg::FUNC_START) begin
            if (r_phase == swthr_pkg::PH_IDLE) begin
                n_temp       = swthr_pkg::INVALID_READING;
                n_hum        = swthr_pkg::INVALID_READING;
                n_success    = 1'b0;
                n_phase      = swthr_pkg::PH_PRE_HIGH;
                n_timer      = '0;
                n_high_width = '0;
                n_bit_count  = '0;
                n_frame      = '0;
            end
        end else begin
            case (r_phase)
                swthr_pkg::PH_PRE_HIGH, swthr_pkg::PH_START_LOW, swthr_pkg::PH_RELEASE: begin
                    if (drive_hit) begin
                        n_phase = drive_next;
                        n_timer = '0;
                    end else begin
                        n_timer = timer_inc;
                    end
                end
                swthr_pkg::PH_WAIT_HIGH, swthr_pkg::PH_WAIT_LOW, swthr_pkg::PH_BIT_LOW: begin
                    n_timer = timer_inc;
                    if (r_phase == swthr_pkg::PH_WAIT_HIGH && lvl) begin
                        n_phase = swthr_pkg::PH_WAIT_LOW;
                    end else if (r_phase == swthr_pkg::PH_WAIT_LOW && !lvl) begin
                        n_phase = swthr_pkg::PH_BIT_LOW;
                    end else if (r_phase == swthr_pkg::PH_BIT_LOW && lvl) begin
                        n_phase      = swthr_pkg::PH_BIT_HIGH;
                        n_high_width = 10'd1;
                    end
                    if (timed_out) begin
                        n_phase      = swthr_pkg::PH_IDLE;
                        n_timer      = '0;
                        n_high_width = '0;
                        n_success    = 1'b0;
                        done         = 1'b1;
                    end
                end
                swthr_pkg::PH_BIT_HIGH: begin
                    if (lvl) begin
                        if (!(&r_high_width)) begin
                            n_high_width = r_high_width + 1'b1;
                        end
                        n_timer = timer_inc;
                        if (timed_out) begin
                            n_phase      = swthr_pkg::PH_IDLE;
                            n_timer      = '0;
                            n_high_width = '0;
                            n_success    = 1'b0;
                            done         = 1'b1;
                        end
                    end else begin
                        n_frame      = frame_new;
                        n_bit_count  = bits_new;
                        n_high_width = '0;
                        if (bits_new >= swthr_pkg::BIT_CNT_W'(swthr_pkg::FRAME_BITS)) begin
                            if (frame_ok) begin
                                n_temp = temp_calc;
                                n_hum  = hum_calc;
                            end
                            n_phase   = swthr_pkg::PH_IDLE;
                            n_timer   = '0;
                            n_success = frame_ok;
                            done      = 1'b1;
                        end else begin
                            n_phase = swthr_pkg::PH_BIT_LOW;
                            n_timer = timer_inc;
                            if (timed_out) begin
                                n_phase   = swthr_pkg::PH_IDLE;
                                n_timer   = '0;
                                n_success = 1'b0;
                                done      = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= swthr_pkg::PH_IDLE;
            r_timer      <= '0;
            r_high_width <= '0;
            r_bit_count  <= '0;
            r_frame      <= '0;
            r_temp       <= swthr_pkg::INVALID_READING;
            r_hum        <= swthr_pkg::INVALID_READING;
            r_success    <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_timer      <= n_timer;
            r_high_width <= n_high_width;
            r_bit_count  <= n_bit_count;
            r_frame      <= n_frame;
            r_temp       <= n_temp;
            r_hum        <= n_hum;
            r_success    <= n_success;
        end
    end

    always_comb begin
        o_result.drive_line = (n_phase == swthr_pkg::PH_PRE_HIGH)
                           || (n_phase == swthr_pkg::PH_START_LOW)
                           || (n_phase == swthr_pkg::PH_RELEASE);
        o_result.drive_high = (n_phase == swthr_pkg::PH_PRE_HIGH)
                           || (n_phase == swthr_pkg::PH_RELEASE);
        o_result.busy_res         = (n_phase != swthr_pkg::PH_IDLE);
        o_result.done_res         = done;
        o_result.success          = n_success;
        o_result.temperature_x100 = n_temp;
        o_result.humidity_x100    = n_hum;
    end

endmodule

>>> design/swthr_out_stage.sv
module swthr_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  swthr_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_can_take,
    output swthr_pkg::t_result o_result
);

    logic               r_valid;
    logic               n_valid;
    swthr_pkg::t_result r_result;

    assign o_can_take = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> design/single_wire_temp_humidity_reader_core.sv
// Reader for a single-wire temperature and humidity sensor.
// Input words arrive on i_valid/o_ready: each is either a one-microsecond tick
// carrying the sampled line level, or a request to start a read.
// Every input word yields exactly one output word on o_valid/i_ready, holding
// the line drive, busy, done, success and both readings after that word.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data, at once and without acknowledgement; the user must write them
// only while the block is idle, as the block itself does not enforce it. The
// sequencer state is updated once for each word moving from the input
// register through the sequencer into the output register. Throughput is
// one word per cycle while i_ready is high. When the receiver stalls, the
// output register holds its word, the input register takes one more word,
// and o_ready then falls until a word leaves. Reset empties both registers,
// returns the sequencer to idle with both readings at -27300 and success
// clear, and loads the default configuration.
module single_wire_temp_humidity_reader_core #(
    parameter int TIMER_BITS = swthr_pkg::TIMER_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_func,
    input  logic                                   i_line_level,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_drive_line,
    output logic                                   o_drive_high,
    output logic                                   o_busy_res,
    output logic                                   o_done_res,
    output logic                                   o_success,
    output logic signed [swthr_pkg::READING_W-1:0] o_temperature_x100,
    output logic signed [swthr_pkg::READING_W-1:0] o_humidity_x100,
    input  logic                                   i_cfg_we,
    input  logic [swthr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [swthr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    swthr_pkg::t_cfg    r_cfg;
    swthr_pkg::t_item   in_item;
    swthr_pkg::t_item   stage_item;
    swthr_pkg::t_result next_result;
    swthr_pkg::t_result out_result;
    logic               stage_valid;
    logic               out_can_take;
    logic               step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_high_us      <= swthr_pkg::PRE_HIGH_RST;
            r_cfg.start_low_us     <= swthr_pkg::START_LOW_RST;
            r_cfg.release_us       <= swthr_pkg::RELEASE_RST;
            r_cfg.timeout_us       <= swthr_pkg::TIMEOUT_RST;
            r_cfg.one_threshold_us <= swthr_pkg::ONE_THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swthr_pkg::CFG_PRE_HIGH:   r_cfg.pre_high_us  <= i_cfg_data;
                swthr_pkg::CFG_START_LOW:  r_cfg.start_low_us <= i_cfg_data;
                swthr_pkg::CFG_RELEASE: begin
                    r_cfg.release_us <= i_cfg_data[swthr_pkg::SHORT_W-1:0];
                end
                swthr_pkg::CFG_TIMEOUT: begin
                    r_cfg.timeout_us <= i_cfg_data[swthr_pkg::SHORT_W-1:0];
                end
                swthr_pkg::CFG_ONE_THRESH: begin
                    r_cfg.one_threshold_us <= i_cfg_data[swthr_pkg::SHORT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign in_item.func       = i_func;
    assign in_item.line_level = i_line_level;
    assign step               = stage_valid && out_can_take;

    swthr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (out_can_take),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    swthr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (stage_item),
        .i_cfg    (r_cfg),
        .o_result (next_result)
    );

    swthr_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (next_result),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_can_take (out_can_take),
        .o_result   (out_result)
    );

    assign o_drive_line       = out_result.drive_line;
    assign o_drive_high       = out_result.drive_high;
    assign o_busy_res         = out_result.busy_res;
    assign o_done_res         = out_result.done_res;
    assign o_success          = out_result.success;
    assign o_temperature_x100 = out_result.temperature_x100;
    assign o_humidity_x100    = out_result.humidity_x100;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("read reported done while still busy");

    a_success_has_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_success |->
            (o_temperature_x100 != swthr_pkg::INVALID_READING)
            && (o_humidity_x100 != swthr_pkg::INVALID_READING))
        else $error("successful read left an invalid reading");

    a_drive_high_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_high |-> o_drive_line && o_busy_res)
        else $error("high level shown without the line being driven");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word present just after reset");

endmodule
